// ----- rtl/arlt_pkg.sv -----
package arlt_pkg;

  // Input command codes.
  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_TOGGLE = 3'd1,
    CMD_SEND   = 3'd2,
    CMD_ACK    = 3'd3,
    CMD_HBEAT  = 3'd4,
    CMD_REPORT = 3'd5
  } cmd_e;

  // Link event codes on the result.
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_UP   = 2'd1,
    EV_LOST = 2'd2
  } link_event_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RETRIES = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HB_TIMEOUT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PEER_READY  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PROTO_VER   = 3'd4;

  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 56;

  typedef struct packed {
    logic [15:0] ack_timeout;
    logic [7:0]  max_retries;
    logic [19:0] heartbeat_timeout;
    logic        peer_ready;
    logic [7:0]  accept_version;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  mask;
    logic [7:0]  new_state;
    logic [15:0] msg_seq;
    logic [7:0]  reported_lights;
    logic [7:0]  msg_version;
  } item_t;

  typedef struct packed {
    logic        awaiting_ack;
    logic [7:0]  wanted_lights;
    logic        link_up;
    logic [1:0]  link_event;
    logic [7:0]  report_lights;
    logic        report_valid;
    logic [7:0]  send_lights;
    logic [7:0]  send_mask;
    logic [15:0] send_seq;
    logic        send_valid;
  } result_t;

endpackage

// ----- rtl/arlt_cfg_regs.sv -----
module arlt_cfg_regs
  import arlt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register decode; writes to unused indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACK_TIMEOUT: cfg_d.ack_timeout = cfg_wdata_i[15:0];
        CFG_MAX_RETRIES: cfg_d.max_retries = cfg_wdata_i[7:0];
        CFG_HB_TIMEOUT:  cfg_d.heartbeat_timeout = cfg_wdata_i[19:0];
        CFG_PEER_READY:  cfg_d.peer_ready = cfg_wdata_i[0];
        CFG_PROTO_VER:   cfg_d.accept_version = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_timeout       <= 16'd200;
      cfg_q.max_retries       <= 8'd3;
      cfg_q.heartbeat_timeout <= 20'd10000;
      cfg_q.peer_ready        <= 1'b0;
      cfg_q.accept_version    <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/arlt_core.sv -----
module arlt_core
  import arlt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [15:0] seq_q, seq_d;
  logic        pend_q, pend_d;
  logic [15:0] pend_seq_q, pend_seq_d;
  logic [7:0]  pend_mask_q, pend_mask_d;
  logic [7:0]  pend_lights_q, pend_lights_d;
  logic [7:0]  retry_q, retry_d;
  logic [31:0] time_q, time_d;
  logic [31:0] sent_q, sent_d;
  logic [31:0] heard_q, heard_d;
  logic [7:0]  desired_q, desired_d;
  logic [7:0]  confirmed_q, confirmed_d;
  logic        conn_q, conn_d;

  logic        ver_ok;
  logic        do_issue;
  logic [7:0]  issue_lights;
  logic        do_heard;
  logic [7:0]  toggled;
  logic [31:0] time_inc;
  logic [31:0] ack_elapsed;
  logic [31:0] hb_elapsed;
  result_t     res;

  // Elapsed times are taken against the time after this tick.
  assign ver_ok = (item_i.msg_version == cfg_i.accept_version);
  assign toggled = desired_q ^ item_i.mask;
  assign time_inc = time_q + 32'd1;
  assign ack_elapsed = time_inc - sent_q;
  assign hb_elapsed = time_inc - heard_q;

  // Decide what the item does.
  always_comb begin
    do_issue     = 1'b0;
    issue_lights = item_i.new_state;
    do_heard     = 1'b0;
    case (item_i.command) inside
      CMD_TOGGLE: begin
        do_issue     = cfg_i.peer_ready;
        issue_lights = toggled & item_i.mask;
      end
      CMD_SEND: begin
        do_issue = cfg_i.peer_ready;
      end
      CMD_ACK, CMD_HBEAT, CMD_REPORT: begin
        do_heard = ver_ok;
      end
      default: ;
    endcase
  end

  // Next state and result for one item.
  always_comb begin
    seq_d         = seq_q;
    pend_d        = pend_q;
    pend_seq_d    = pend_seq_q;
    pend_mask_d   = pend_mask_q;
    pend_lights_d = pend_lights_q;
    retry_d       = retry_q;
    time_d        = time_q;
    sent_d        = sent_q;
    heard_d       = heard_q;
    desired_d     = desired_q;
    confirmed_d   = confirmed_q;
    conn_d        = conn_q;
    res           = '0;

    // Clock tick: resend or give up, then check the link.
    if (item_i.command == CMD_TICK) begin
      time_d = time_inc;
      if (pend_q && (ack_elapsed >= {16'd0, cfg_i.ack_timeout})) begin
        if (retry_q < cfg_i.max_retries) begin
          retry_d        = retry_q + 8'd1;
          sent_d         = time_inc;
          res.send_valid = 1'b1;
          res.send_seq   = pend_seq_q;
          res.send_mask  = pend_mask_q;
          res.send_lights = pend_lights_q;
        end else begin
          pend_d            = 1'b0;
          desired_d         = confirmed_q;
          res.report_valid  = 1'b1;
          res.report_lights = confirmed_q;
        end
      end
      if (conn_q && (hb_elapsed >= {12'd0, cfg_i.heartbeat_timeout})) begin
        conn_d         = 1'b0;
        res.link_event = EV_LOST;
      end
    end

    // Optimistic update of the wanted state on a toggle.
    if (item_i.command == CMD_TOGGLE) begin
      desired_d = toggled;
    end

    // New command frame; replaces any pending one.
    if (do_issue) begin
      seq_d           = seq_q + 16'd1;
      pend_seq_d      = seq_d;
      pend_mask_d     = item_i.mask;
      pend_lights_d   = issue_lights;
      pend_d          = 1'b1;
      retry_d         = 8'd0;
      sent_d          = time_q;
      res.send_valid  = 1'b1;
      res.send_seq    = seq_d;
      res.send_mask   = item_i.mask;
      res.send_lights = issue_lights;
    end

    // Something was heard from the peer.
    if (do_heard) begin
      confirmed_d       = item_i.reported_lights;
      heard_d           = time_q;
      res.report_valid  = 1'b1;
      res.report_lights = item_i.reported_lights;
      if (!conn_q) begin
        conn_d         = 1'b1;
        res.link_event = EV_UP;
      end
      if (item_i.command == CMD_ACK && item_i.msg_seq == pend_seq_q) begin
        pend_d = 1'b0;
      end
      if (item_i.command != CMD_HBEAT) begin
        desired_d = item_i.reported_lights;
      end
    end

    res.link_up       = conn_d;
    res.wanted_lights = desired_d;
    res.awaiting_ack  = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= '0;
      pend_q        <= 1'b0;
      pend_seq_q    <= '0;
      pend_mask_q   <= '0;
      pend_lights_q <= '0;
      retry_q       <= '0;
      time_q        <= '0;
      sent_q        <= '0;
      heard_q       <= '0;
      desired_q     <= '0;
      confirmed_q   <= '0;
      conn_q        <= 1'b0;
    end else if (step_i) begin
      seq_q         <= seq_d;
      pend_q        <= pend_d;
      pend_seq_q    <= pend_seq_d;
      pend_mask_q   <= pend_mask_d;
      pend_lights_q <= pend_lights_d;
      retry_q       <= retry_d;
      time_q        <= time_d;
      sent_q        <= sent_d;
      heard_q       <= heard_d;
      desired_q     <= desired_d;
      confirmed_q   <= confirmed_d;
      conn_q        <= conn_d;
    end
  end

  assign result_o = res;

endmodule

// ----- rtl/ack_retry_link_tracker.sv -----
// Stop-and-wait command sender with link tracking.
//
// Input stream (s_axis): one transaction per item; tuser carries the command
// code and tdata the message fields. Output stream (m_axis): exactly one
// transaction per input item, in order, carrying the send frame, the host
// report, the link event and the current status.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
// the stream is idle; a write takes effect at the next clock edge.
//
// A result is offered on m_axis once it has passed the input register, then
// the result register. The block takes one item per cycle unless the receiver
// stalls; the state update is combinational, made of compares and
// increments.
// Reset clears all protocol state and loads the configuration defaults; both
// stream registers come up empty. When the receiver stalls, the result holds
// in the result register and one more item waits in the input register; then
// s_axis_tready drops until the result is taken.
module ack_retry_link_tracker
  import arlt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // mask[7:0], new_state[15:8], msg_seq[31:16], reported_lights[39:32],
  // msg_version[47:40]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // command[2:0]
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // send_valid[0], send_seq[16:1], send_mask[24:17], send_lights[32:25],
  // report_valid[33], report_lights[41:34], link_event[43:42], link_up[44],
  // wanted_lights[52:45], awaiting_ack[53], zero fill [55:54]
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_take;

  arlt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // An item moves on when the result register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.command         <= s_axis_tuser;
      in_q.mask            <= s_axis_tdata[7:0];
      in_q.new_state       <= s_axis_tdata[15:8];
      in_q.msg_seq         <= s_axis_tdata[31:16];
      in_q.reported_lights <= s_axis_tdata[39:32];
      in_q.msg_version     <= s_axis_tdata[47:40];
    end
  end

  arlt_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

endmodule

// ----- rtl/arlt_checker.sv -----
module arlt_checker
  import arlt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A frame is never sent in the same transaction as a host report.
  a_send_or_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[33]))
    else $error("send and report in one transaction");

  // A sent frame always leaves a command awaiting acknowledgment.
  a_send_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[53])
    else $error("frame sent without pending command");

  // Link events agree with the connected flag.
  a_event_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[43:42] == EV_UP) |-> m_axis_tdata[44])
    else $error("link up event with link down");

  a_event_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[43:42] == EV_LOST) |-> !m_axis_tdata[44])
    else $error("link lost event with link up");

endmodule

bind ack_retry_link_tracker arlt_checker u_arlt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
